/* src/bip_pkg.sv */
// shared types, widths and register codes of the binaural panner
package bip_pkg;

  // shared multiplier operands and accumulator
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int RND_W   = ACC_W - 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int DELAY_W    = 7;
  localparam int GAIN_W     = 21;
  localparam int COEF_W     = 16;
  localparam int MIX_W      = 17;

  localparam logic [MIX_W-1:0] Q16_ONE = MIX_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_DELAY,
    REG_RIGHT_DELAY,
    REG_GAIN_LEFT,
    REG_GAIN_RIGHT,
    REG_SHADOW_COEF,
    REG_SHADOW_ON_LEFT,
    REG_MIX_LEVEL
  } reg_idx_t;

  typedef struct packed {
    logic mul_en;    // register a * b
    logic acc_load;  // acc <= product + half
    logic use_acc;   // rounded result from acc + product
  } mac_ctrl_t;

endpackage

/* src/bip_if.sv */
// request channels of the binaural panner: stereo input and stereo result
interface bip_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source(output valid, output left_in, output right_in, input ready);
  modport sink(input valid, input left_in, input right_in, output ready);
endinterface

interface bip_out_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source(output valid, output left_out, output right_out, input ready);
  modport sink(input valid, input left_out, input right_out, output ready);
endinterface

/* src/bip_dly.sv */
// circular mono delay store with per-ear read taps and fill count
module bip_dly
  import bip_pkg::*;
#(
  parameter int DELAY_DEPTH = 128,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic                          rd_right,
  input  logic signed [SAMPLE_BITS-1:0] wr_data,
  input  logic [DELAY_W-1:0]            left_delay,
  input  logic [DELAY_W-1:0]            right_delay,
  output logic signed [SAMPLE_BITS-1:0] sample
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int DW = (AW + 1 > DELAY_W + 1) ? AW + 1 : DELAY_W + 1;
  localparam logic [DW-1:0] DMAX  = DW'(DELAY_DEPTH - 1);
  localparam logic [DW-1:0] DEP   = DW'(DELAY_DEPTH);
  localparam logic [AW:0]   FULL  = (AW + 1)'(DELAY_DEPTH);
  localparam logic [AW-1:0] LASTA = AW'(DELAY_DEPTH - 1);

  logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_r;
  logic signed [SAMPLE_BITS-1:0] mono_r;
  logic [AW-1:0]                 wp_r;
  logic [AW:0]                   fc_r;
  logic                          zero_r, vld_r;
  logic [AW-1:0]                 pend_addr_r;
  logic                          pend_zero_r, pend_vld_r;

  logic [DW-1:0] dl_c, dr_c;
  logic [AW-1:0] addr_l, addr_r, rd_addr;

  function automatic logic [DW-1:0] clip(input logic [DELAY_W-1:0] d);
    logic [DW-1:0] dx;
    dx = DW'(d);
    return (dx > DMAX) ? DMAX : dx;
  endfunction

  // wp - d modulo the depth
  function automatic logic [AW-1:0] back(input logic [AW-1:0] wp, input logic [DW-1:0] d);
    logic [DW-1:0] w, s;
    w = DW'(wp);
    s = (w >= d) ? (w - d) : (w + DEP - d);
    return s[AW-1:0];
  endfunction

  assign dl_c    = clip(left_delay);
  assign dr_c    = clip(right_delay);
  assign addr_l  = back(wp_r, dl_c);
  assign addr_r  = back(wp_r, dr_c);
  assign rd_addr = rd_right ? pend_addr_r : addr_l;

  // entries are written in order from zero, so anything at or past the fill count reads zero
  assign sample = zero_r ? mono_r : (vld_r ? rd_r : '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
    if (wr_en || rd_right) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      fc_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r        <= (wp_r == LASTA) ? '0 : wp_r + 1'b1;
        fc_r        <= (fc_r == FULL) ? fc_r : fc_r + 1'b1;
        mono_r      <= wr_data;
        zero_r      <= (dl_c == '0);
        vld_r       <= ((AW + 1)'(addr_l) < fc_r);
        pend_addr_r <= addr_r;
        pend_zero_r <= (dr_c == '0);
        pend_vld_r  <= ((AW + 1)'(addr_r) < fc_r);
      end else if (rd_right) begin
        zero_r <= pend_zero_r;
        vld_r  <= pend_vld_r;
      end
    end
  end

endmodule

/* src/bip_mac.sv */
// shared signed multiplier with accumulator, q16 rounding and 32-bit saturation
module bip_mac
  import bip_pkg::*;
(
  input  logic                      clk,
  input  mac_ctrl_t                 ctrl,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [RND_W-1:0]   rnd,
  output logic signed [31:0]        rnd_sat32
);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(32768);
  localparam logic signed [RND_W-1:0] S32_MAX = RND_W'(64'sd2147483647);
  localparam logic signed [RND_W-1:0] S32_MIN = -RND_W'(64'sd2147483648);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_x;
  logic signed [ACC_W-1:0]  sum;

  assign prod_x = ACC_W'(prod_r);
  assign sum    = ctrl.use_acc ? (acc_r + prod_x) : (prod_x + HALF);
  assign rnd    = RND_W'(sum >>> 16);

  always_comb begin
    priority if (rnd > S32_MAX) begin
      rnd_sat32 = 32'(S32_MAX);
    end else if (rnd < S32_MIN) begin
      rnd_sat32 = 32'(S32_MIN);
    end else begin
      rnd_sat32 = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= PROD_W'(a * b);
    end
    if (ctrl.acc_load) begin
      acc_r <= prod_x + HALF;
    end
  end

endmodule

/* src/binaural_itd_ild_panner.sv */
// binaural panner top level: registers, sequencer and output register
//
// Input channel in_chan carries one stereo sample pair per request; the
// result channel out_chan returns one stereo pair per request, in order.
// Registers are written through cfg_we / cfg_idx / cfg_wdata; the user
// must write them only while idle, the block does not enforce it.
// Unknown indexes are dropped and bits above a register's width masked.
// in_chan.ready is high only while the sequencer is idle. One shared
// 32x22 multiplier forms an accepted request's eight products (two gains,
// two filter terms, four mix terms) one per cycle; a new request is taken
// once the sequencer is idle again, and the final step loads the result.
// The output register holds a result while the receiver stalls; the
// sequencer then waits in its last step and the next request is blocked.
// Reset clears the sequencer, registers, filter states and the write
// pointer; the delay store is not swept, a fill count makes unwritten
// entries read as zero, so the block is ready right after reset.
module binaural_itd_ild_panner
  import bip_pkg::*;
#(
  parameter int DELAY_DEPTH = 128,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bip_in_if.sink                in_chan,
  bip_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic signed [RND_W-1:0] SB_MAX = RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RND_W-1:0] SB_MIN = -RND_W'(64'sd1 <<< (SAMPLE_BITS - 1));

  typedef enum logic [3:0] {
    ST_IDLE, ST_GL, ST_GR, ST_SC, ST_SF, ST_DL, ST_WL, ST_DR, ST_WR, ST_FIN
  } state_t;

  state_t state_r;

  logic [DELAY_W-1:0] left_delay_r, right_delay_r;
  logic [GAIN_W-1:0]  gain_left_r, gain_right_r;
  logic [COEF_W-1:0]  coef_r;
  logic               shadow_left_r;
  logic [MIX_W-1:0]   mix_r;

  logic signed [SAMPLE_BITS-1:0] l_r, r_r, res_l_r;
  logic signed [SAMPLE_BITS-1:0] left_out_r, right_out_r;
  logic                          out_valid_r;
  logic signed [31:0]            sig_l_r, sig_r_r, st_l_r, st_r_r;

  logic                          in_fire;
  logic signed [SAMPLE_BITS:0]   pair_sum;
  logic signed [SAMPLE_BITS-1:0] mono, dly_sample;
  logic [MIX_W-1:0]              mix_c, one_m_mix, one_m_coef;
  logic signed [31:0]            sig_far, st_far;
  mac_ctrl_t                     mctl;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [RND_W-1:0]       rnd;
  logic signed [31:0]            rnd32;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sb(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] c;
    priority if (v > SB_MAX) begin
      c = SB_MAX;
    end else if (v < SB_MIN) begin
      c = SB_MIN;
    end else begin
      c = v;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);

  assign out_chan.valid     = out_valid_r;
  assign out_chan.left_out  = left_out_r;
  assign out_chan.right_out = right_out_r;

  // floor of the average
  assign pair_sum = (SAMPLE_BITS + 1)'(in_chan.left_in) + (SAMPLE_BITS + 1)'(in_chan.right_in);
  assign mono     = pair_sum[SAMPLE_BITS:1];

  assign mix_c      = (mix_r > Q16_ONE) ? Q16_ONE : mix_r;
  assign one_m_mix  = Q16_ONE - mix_c;
  assign one_m_coef = Q16_ONE - MIX_W'(coef_r);
  assign sig_far    = shadow_left_r ? sig_l_r : sig_r_r;
  assign st_far     = shadow_left_r ? st_l_r : st_r_r;

  bip_dly #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dly (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (in_fire),
    .rd_right   (state_r == ST_GL),
    .wr_data    (mono),
    .left_delay (left_delay_r),
    .right_delay(right_delay_r),
    .sample     (dly_sample)
  );

  // operand selection and post-processing of the product from the step before
  always_comb begin
    mctl  = '0;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_GL: begin
        mctl.mul_en = 1'b1;
        mul_a       = MUL_A_W'(dly_sample);
        mul_b       = MUL_B_W'({1'b0, gain_left_r});
      end
      ST_GR: begin
        mctl.mul_en = 1'b1;
        mul_a       = MUL_A_W'(dly_sample);
        mul_b       = MUL_B_W'({1'b0, gain_right_r});
      end
      ST_SC: begin
        mctl.mul_en = 1'b1;
        mul_a       = st_far;
        mul_b       = MUL_B_W'({1'b0, coef_r});
      end
      ST_SF: begin
        mctl.mul_en   = 1'b1;
        mctl.acc_load = 1'b1;
        mul_a         = sig_far;
        mul_b         = MUL_B_W'({1'b0, one_m_coef});
      end
      ST_DL: begin
        mctl.mul_en  = 1'b1;
        mctl.use_acc = 1'b1;
        mul_a        = MUL_A_W'(l_r);
        mul_b        = MUL_B_W'({1'b0, one_m_mix});
      end
      ST_WL: begin
        mctl.mul_en   = 1'b1;
        mctl.acc_load = 1'b1;
        mul_a         = sig_l_r;
        mul_b         = MUL_B_W'({1'b0, mix_c});
      end
      ST_DR: begin
        mctl.mul_en  = 1'b1;
        mctl.use_acc = 1'b1;
        mul_a        = MUL_A_W'(r_r);
        mul_b        = MUL_B_W'({1'b0, one_m_mix});
      end
      ST_WR: begin
        mctl.mul_en   = 1'b1;
        mctl.acc_load = 1'b1;
        mul_a         = sig_r_r;
        mul_b         = MUL_B_W'({1'b0, mix_c});
      end
      ST_FIN: begin
        mctl.use_acc = 1'b1;
      end
      default: begin
        mctl = '0;
      end
    endcase
  end

  bip_mac u_mac (
    .clk      (clk),
    .ctrl     (mctl),
    .a        (mul_a),
    .b        (mul_b),
    .rnd      (rnd),
    .rnd_sat32(rnd32)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      st_l_r        <= '0;
      st_r_r        <= '0;
      left_delay_r  <= '0;
      right_delay_r <= '0;
      gain_left_r   <= GAIN_W'(65536);
      gain_right_r  <= GAIN_W'(65536);
      coef_r        <= '0;
      shadow_left_r <= 1'b0;
      mix_r         <= Q16_ONE;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_idx))
          REG_LEFT_DELAY:     left_delay_r  <= cfg_wdata[DELAY_W-1:0];
          REG_RIGHT_DELAY:    right_delay_r <= cfg_wdata[DELAY_W-1:0];
          REG_GAIN_LEFT:      gain_left_r   <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_RIGHT:     gain_right_r  <= cfg_wdata[GAIN_W-1:0];
          REG_SHADOW_COEF:    coef_r        <= cfg_wdata[COEF_W-1:0];
          REG_SHADOW_ON_LEFT: shadow_left_r <= cfg_wdata[0];
          REG_MIX_LEVEL:      mix_r         <= cfg_wdata[MIX_W-1:0];
          default: ;
        endcase
      end

      // the final step reloads the output register itself
      if (out_valid_r && out_chan.ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            l_r     <= in_chan.left_in;
            r_r     <= in_chan.right_in;
            state_r <= ST_GL;
          end
        end
        ST_GL: state_r <= ST_GR;
        ST_GR: begin
          sig_l_r <= rnd32;
          state_r <= ST_SC;
        end
        ST_SC: begin
          sig_r_r <= rnd32;
          state_r <= ST_SF;
        end
        ST_SF: state_r <= ST_DL;
        ST_DL: begin
          // far ear takes the filtered value, the near ear's state holds
          if (shadow_left_r) begin
            st_l_r  <= rnd32;
            sig_l_r <= rnd32;
          end else begin
            st_r_r  <= rnd32;
            sig_r_r <= rnd32;
          end
          state_r <= ST_WL;
        end
        ST_WL: state_r <= ST_DR;
        ST_DR: begin
          res_l_r <= sat_sb(rnd);
          state_r <= ST_WR;
        end
        ST_WR: state_r <= ST_FIN;
        ST_FIN: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            left_out_r  <= res_l_r;
            right_out_r <= sat_sb(rnd);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_GL)
    else $error("accepted request did not start the sequencer");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside the final step");

  a_stall_holds_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_chan.ready) |=> state_r == ST_FIN)
    else $error("sequencer left the final step while the output was stalled");

endmodule
